// File: hdl/websocket_frame_parser_macros.svh
// ----------------------------------------------------------------------------
// websocket frame parser assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_PARSER_MACROS_SVH
`define WEBSOCKET_FRAME_PARSER_MACROS_SVH

`ifndef ASSERT_OFF

`define WFP_ASSERT(lbl, clk_s, rst_n_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) \
		else $error("websocket frame parser assertion failed");

`define WFP_ASSERT_IMPLIES(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("websocket frame parser implication failed");

`define WFP_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("websocket frame parser next-cycle check failed");

`else

`define WFP_ASSERT(lbl, clk_s, rst_n_s, prop)
`define WFP_ASSERT_IMPLIES(lbl, clk_s, rst_n_s, ante, cons)
`define WFP_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons)

`endif

`endif

// File: hdl/wfp_pkg.sv
// ----------------------------------------------------------------------------
// websocket frame parser package
// frame kind codes, opcodes, header length codes and opcode decoding
// ----------------------------------------------------------------------------
package wfp_pkg;

	typedef logic [2:0] kind_t;

	localparam kind_t KIND_TEXT         = 3'd0;
	localparam kind_t KIND_TEXT_PART    = 3'd1;
	localparam kind_t KIND_BINARY       = 3'd2;
	localparam kind_t KIND_BINARY_PART  = 3'd3;
	localparam kind_t KIND_CLOSE        = 3'd4;
	localparam kind_t KIND_PING         = 3'd5;
	localparam kind_t KIND_PONG         = 3'd6;
	localparam kind_t KIND_ERROR        = 3'd7;

	localparam logic [3:0] OP_CONT   = 4'h0;
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_PONG   = 4'hA;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	function automatic kind_t kind_of(input logic [7:0] b0);
		kind_t k;
		case (b0[3:0])
			OP_CONT, OP_TEXT: k = b0[7] ? KIND_TEXT : KIND_TEXT_PART;
			OP_BINARY:        k = b0[7] ? KIND_BINARY : KIND_BINARY_PART;
			OP_CLOSE:         k = KIND_CLOSE;
			OP_PING:          k = KIND_PING;
			OP_PONG:          k = KIND_PONG;
			default:          k = KIND_ERROR;
		endcase
		return k;
	endfunction

endpackage

// File: hdl/websocket_frame_parser.sv
// ----------------------------------------------------------------------------
// websocket frame parser
// an input transaction passes the input reg and then the result reg
// throughput: 1 byte per cycle unless out_ready stalls the single-byte update
// asynchronous active-low reset returns the parser to the first header byte
// ----------------------------------------------------------------------------
`include "websocket_frame_parser_macros.svh"

module websocket_frame_parser
	import wfp_pkg::*;
#(
	parameter int LENGTH_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  payload_byte,
	output logic        byte_valid,
	output logic [2:0]  frame_kind,
	output logic        end_of_frame,
	output logic        was_masked
);

	typedef enum logic [2:0] {
		PH_HDR0 = 3'd0,
		PH_HDR1 = 3'd1,
		PH_EXT  = 3'd2,
		PH_KEY  = 3'd3,
		PH_DATA = 3'd4
	} phase_t;

	localparam int LW = LENGTH_WIDTH;

	phase_t          phase_q, phase_d;
	kind_t           kind_q, kind_d;
	logic            masked_q, masked_d;
	logic [3:0]      cnt_q, cnt_d;
	logic [LW-1:0]   rem_q, rem_d;
	logic [31:0]     key_q, key_d;
	logic [1:0]      idx_q, idx_d;

	logic            valid_s1;
	logic [7:0]      byte_s1;

	logic            out_valid_q;
	logic [7:0]      payload_q;
	logic            byte_valid_q;
	kind_t           kind_out_q;
	logic            eof_q;
	logic            masked_out_q;

	logic            advance;
	logic            res_v;
	logic [7:0]      res_data;
	logic            res_bv;
	logic            res_eof;
	logic [7:0]      key_byte;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign key_byte = key_q[{~idx_q, 3'b000} +: 8];

	always_comb begin
		phase_d  = phase_q;
		kind_d   = kind_q;
		masked_d = masked_q;
		cnt_d    = cnt_q;
		rem_d    = rem_q;
		key_d    = key_q;
		idx_d    = idx_q;
		res_v    = 1'b0;
		res_data = 8'h00;
		res_bv   = 1'b0;
		res_eof  = 1'b0;
		case (phase_q)
			PH_HDR1: begin
				masked_d = byte_s1[7];
				key_d    = '0;
				idx_d    = 2'd0;
				rem_d    = '0;
				if (byte_s1[6:0] == LEN_EXT16) begin
					cnt_d   = EXT16_BYTES;
					phase_d = PH_EXT;
				end else if (byte_s1[6:0] == LEN_EXT64) begin
					cnt_d   = EXT64_BYTES;
					phase_d = PH_EXT;
				end else begin
					rem_d = LW'(byte_s1[6:0]);
					if (byte_s1[7]) begin
						cnt_d   = KEY_BYTES;
						phase_d = PH_KEY;
					end else if (byte_s1[6:0] == 7'd0) begin
						phase_d = PH_HDR0;
						res_v   = 1'b1;
						res_eof = 1'b1;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_EXT: begin
				if (rem_q[LW-1 -: 8] != 8'h00) begin
					rem_d = '1;
				end else begin
					rem_d = {rem_q[LW-9:0], byte_s1};
				end
				cnt_d = cnt_q - 4'd1;
				if (cnt_d == 4'd0) begin
					if (masked_q) begin
						cnt_d   = KEY_BYTES;
						phase_d = PH_KEY;
					end else if (rem_d == '0) begin
						phase_d = PH_HDR0;
						res_v   = 1'b1;
						res_eof = 1'b1;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], byte_s1};
				cnt_d = cnt_q - 4'd1;
				if (cnt_d == 4'd0) begin
					if (rem_q == '0) begin
						phase_d = PH_HDR0;
						res_v   = 1'b1;
						res_eof = 1'b1;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				res_v    = 1'b1;
				res_bv   = 1'b1;
				res_data = masked_q ? (byte_s1 ^ key_byte) : byte_s1;
				idx_d    = idx_q + 2'd1;
				rem_d    = rem_q - LW'(1);
				res_eof  = (rem_d == '0);
				if (res_eof) begin
					phase_d = PH_HDR0;
				end
			end
			default: begin
				kind_d   = kind_of(byte_s1);
				masked_d = 1'b0;
				cnt_d    = 4'd0;
				rem_d    = '0;
				key_d    = '0;
				idx_d    = 2'd0;
				phase_d  = PH_HDR1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR0;
			kind_q      <= KIND_TEXT;
			masked_q    <= 1'b0;
			cnt_q       <= 4'd0;
			rem_q       <= '0;
			key_q       <= '0;
			idx_q       <= 2'd0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance && res_v) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				phase_q  <= phase_d;
				kind_q   <= kind_d;
				masked_q <= masked_d;
				cnt_q    <= cnt_d;
				rem_q    <= rem_d;
				key_q    <= key_d;
				idx_q    <= idx_d;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
		if (advance && res_v) begin
			payload_q    <= res_data;
			byte_valid_q <= res_bv;
			kind_out_q   <= kind_d;
			eof_q        <= res_eof;
			masked_out_q <= masked_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_byte = payload_q;
	assign byte_valid   = byte_valid_q;
	assign frame_kind   = kind_out_q;
	assign end_of_frame = eof_q;
	assign was_masked   = masked_out_q;

	`WFP_ASSERT_IMPLIES(a_empty_end, clk, arst_n, out_valid_q && !byte_valid_q, eof_q && !(|payload_q))
	`WFP_ASSERT_NEXT(a_data_result, clk, arst_n, advance && (phase_q == PH_DATA), out_valid)
	`WFP_ASSERT_IMPLIES(a_key_count, clk, arst_n, phase_q == PH_KEY, (cnt_q != 4'd0) && (cnt_q <= KEY_BYTES))
	`WFP_ASSERT_IMPLIES(a_data_len, clk, arst_n, phase_q == PH_DATA, rem_q != '0)

endmodule

// File: tb/websocket_frame_parser_tb.sv
// ----------------------------------------------------------------------------
// websocket frame parser testbench
// streams well-formed frames of every opcode, extended length form and mask
// setting, plus header noise, through the byte input with random idle cycles
// on both sides; a scoreboard tracks the header walk of the parser, predicts
// each payload byte after unmasking and empty-frame end, and checks every
// result transaction field by field in order
// ----------------------------------------------------------------------------
module websocket_frame_parser_tb;
	import wfp_pkg::*;

	localparam int          LEN_W   = 64;
	localparam logic [63:0] LEN_MAX = {64{1'b1}} >> (64 - LEN_W);

	typedef enum logic [2:0] {P_HDR0, P_HDR1, P_EXT, P_KEY, P_DATA} parse_phase_t;
	typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_t;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		kind_t      kind;
		logic       eof;
		logic       masked;
	} frame_result_t;

	class frame_scoreboard;
		parse_phase_t  phase;
		kind_t         kind;
		logic          masked;
		logic [3:0]    bytes_due;
		logic [63:0]   remaining;
		logic [31:0]   key;
		logic [1:0]    key_idx;
		frame_result_t owed[$];
		int            errors;

		function new();
			phase     = P_HDR0;
			kind      = KIND_TEXT;
			masked    = 1'b0;
			bytes_due = '0;
			remaining = '0;
			key       = '0;
			key_idx   = '0;
			errors    = 0;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		function kind_t decode_kind(input logic [7:0] b0);
			logic [3:0] op;
			op = b0[3:0];
			if (op == OP_CONT || op == OP_TEXT)
				return b0[7] ? KIND_TEXT : KIND_TEXT_PART;
			if (op == OP_BINARY)
				return b0[7] ? KIND_BINARY : KIND_BINARY_PART;
			if (op == OP_CLOSE)
				return KIND_CLOSE;
			if (op == OP_PING)
				return KIND_PING;
			if (op == OP_PONG)
				return KIND_PONG;
			return KIND_ERROR;
		endfunction

		function void owe(input logic [7:0] d, input logic v, input logic eof);
			frame_result_t r;
			r.data   = d;
			r.valid  = v;
			r.kind   = kind;
			r.eof    = eof;
			r.masked = masked;
			owed = {owed, r};
		endfunction

		function void header_complete();
			if (masked) begin
				bytes_due = KEY_BYTES;
				phase     = P_KEY;
			end else if (remaining == 0) begin
				phase = P_HDR0;
				owe(8'h00, 1'b0, 1'b1);
			end else begin
				phase = P_DATA;
			end
		endfunction

		// one accepted stream byte
		function void take_byte(input logic [7:0] b);
			logic [7:0] d;
			int         sh;
			case (phase)
				P_HDR1: begin
					masked    = b[7];
					key       = '0;
					key_idx   = '0;
					remaining = '0;
					if (b[6:0] == LEN_EXT16) begin
						bytes_due = EXT16_BYTES;
						phase     = P_EXT;
					end else if (b[6:0] == LEN_EXT64) begin
						bytes_due = EXT64_BYTES;
						phase     = P_EXT;
					end else begin
						remaining = 64'(b[6:0]);
						header_complete();
					end
				end
				P_EXT: begin
					if (remaining > (LEN_MAX >> 8))
						remaining = LEN_MAX;
					else
						remaining = ((remaining << 8) | 64'(b)) & LEN_MAX;
					bytes_due = bytes_due - 4'd1;
					if (bytes_due == 0)
						header_complete();
				end
				P_KEY: begin
					key       = {key[23:0], b};
					bytes_due = bytes_due - 4'd1;
					if (bytes_due == 0) begin
						if (remaining == 0) begin
							phase = P_HDR0;
							owe(8'h00, 1'b0, 1'b1);
						end else begin
							phase = P_DATA;
						end
					end
				end
				P_DATA: begin
					sh = 24 - 8 * int'(key_idx);
					d  = masked ? (b ^ 8'(key >> sh)) : b;
					key_idx   = key_idx + 2'd1;
					remaining = remaining - 64'd1;
					if (remaining == 0)
						phase = P_HDR0;
					owe(d, 1'b1, remaining == 0);
				end
				default: begin
					kind      = decode_kind(b);
					masked    = 1'b0;
					bytes_due = '0;
					remaining = '0;
					key       = '0;
					key_idx   = '0;
					phase     = P_HDR1;
				end
			endcase
		endfunction

		function void match_result(input frame_result_t got);
			frame_result_t want;
			if (owed.size() == 0) begin
				$error("result transaction with no expectation waiting");
				errors++;
				return;
			end
			want = owed.pop_front();
			if (got.data !== want.data) begin
				$error("payload_byte expected %0h actual %0h", want.data, got.data);
				errors++;
			end
			if (got.valid !== want.valid) begin
				$error("byte_valid expected %0b actual %0b", want.valid, got.valid);
				errors++;
			end
			if (got.kind !== want.kind) begin
				$error("frame_kind expected %0d actual %0d", want.kind, got.kind);
				errors++;
			end
			if (got.eof !== want.eof) begin
				$error("end_of_frame expected %0b actual %0b", want.eof, got.eof);
				errors++;
			end
			if (got.masked !== want.masked) begin
				$error("was_masked expected %0b actual %0b", want.masked, got.masked);
				errors++;
			end
		endfunction
	endclass

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [7:0] in_byte   = 8'h00;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [7:0] payload_byte;
	logic       byte_valid;
	logic [2:0] frame_kind;
	logic       end_of_frame;
	logic       was_masked;

	bit              tx_idle_on = 1'b1;
	bit              rx_idle_on = 1'b1;
	int              bytes_sent = 0;
	frame_scoreboard sb;

	websocket_frame_parser #(
		.LENGTH_WIDTH(LEN_W)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.payload_byte(payload_byte),
		.byte_valid  (byte_valid),
		.frame_kind  (frame_kind),
		.end_of_frame(end_of_frame),
		.was_masked  (was_masked)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n)
			out_ready <= !(rx_idle_on && $urandom_range(0, 99) < 13);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.take_byte(in_byte);
			if (out_valid && out_ready)
				sb.match_result({payload_byte, byte_valid, frame_kind, end_of_frame,
					was_masked});
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while (tx_idle_on && $urandom_range(0, 99) < 13) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [7:0] b0, input logic masked,
			input logic [31:0] len, input len_form_t form, input logic [31:0] key);
		logic [63:0] len64;
		int          i;
		len64 = 64'(len);
		send_byte(b0);
		case (form)
			FORM_EXT16: begin
				send_byte({masked, LEN_EXT16});
				send_byte(len[15:8]);
				send_byte(len[7:0]);
			end
			FORM_EXT64: begin
				send_byte({masked, LEN_EXT64});
				for (i = 0; i < 8; i++)
					send_byte(8'(len64 >> (56 - 8 * i)));
			end
			default: send_byte({masked, len[6:0]});
		endcase
		if (masked)
			for (i = 0; i < 4; i++)
				send_byte(8'(key >> (24 - 8 * i)));
		for (i = 0; i < int'(len); i++)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic random_frame(input bit noisy);
		logic [3:0]  op;
		logic [2:0]  rsv;
		logic [7:0]  b0;
		logic [31:0] len;
		len_form_t   form;
		int          pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0: op = OP_CONT;
			1: op = OP_TEXT;
			2: op = OP_BINARY;
			3: op = OP_CLOSE;
			4: op = OP_PING;
			5: op = OP_PONG;
			6: op = OP_TEXT;
			7: op = OP_BINARY;
			default: op = 4'($urandom_range(0, 15));
		endcase
		rsv = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'b000;
		b0  = noisy ? 8'($urandom_range(0, 255)) : {1'($urandom_range(0, 1)), rsv, op};
		pick = $urandom_range(0, 99);
		if (pick < 70)
			len = $urandom_range(0, 8);
		else if (pick < 95)
			len = $urandom_range(9, 40);
		else
			len = $urandom_range(41, 125);
		pick = $urandom_range(0, 99);
		form = (pick < 80) ? FORM_SHORT : (pick < 92) ? FORM_EXT16 : FORM_EXT64;
		send_frame(b0, 1'($urandom_range(0, 1)), len, form, $urandom());
	endtask

	initial begin
		int f;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty frames, unmasked and masked
		send_frame({1'b1, 3'b000, OP_TEXT}, 1'b0, 0, FORM_SHORT, 32'h0);
		send_frame({1'b1, 3'b000, OP_CLOSE}, 1'b1, 0, FORM_SHORT, 32'hFFFF_FFFF);
		// every opcode, fin toggling, reserved bits set
		for (f = 0; f < 16; f++)
			send_frame({1'(f), 3'(f), 4'(f)}, 1'(f >> 1), (f % 3) + 1, FORM_SHORT, $urandom());
		// extended lengths, non-minimal encodings included
		send_frame({1'b1, 3'b000, OP_BINARY}, 1'b1, 5, FORM_EXT16, 32'hA5C3_0FF0);
		send_frame({1'b0, 3'b000, OP_BINARY}, 1'b0, 0, FORM_EXT16, 32'h0);
		send_frame({1'b1, 3'b000, OP_PING}, 1'b1, 3, FORM_EXT64, 32'h0000_0000);
		send_frame({1'b1, 3'b111, OP_PONG}, 1'b1, 0, FORM_EXT64, 32'h1234_5678);
		send_frame({1'b0, 3'b000, OP_TEXT}, 1'b1, 125, FORM_SHORT, 32'hFF00_FF00);
		wait_idle();

		f = 0;
		while (bytes_sent < 1850) begin
			tx_idle_on = !(f >= 60 && f < 110);
			rx_idle_on = !(f >= 70 && f < 120);
			random_frame($urandom_range(0, 99) < 15);
			f++;
			if (f % 40 == 0)
				wait_idle();
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;

		wait_idle();
		repeat (12) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#(12 * 200000);
		$display("Mismatches found");
		$finish;
	end

endmodule
